// ===== hdl/nmea_rmc_sentence_checker_top_defines.svh =====
// Assertion macros shared by the sentence checker RTL.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef NMEA_RMC_SENTENCE_CHECKER_TOP_DEFINES_SVH
`define NMEA_RMC_SENTENCE_CHECKER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// Clocked check, idle while reset is asserted.
`define NRMC_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Clocked check that also holds during reset.
`define NRMC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define NRMC_ASSERT(lbl, clk, rstn, prop, msg)
`define NRMC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== hdl/nrmc_pkg.sv =====
// Types, character constants and helper functions of the RMC sentence checker.
// No dependencies; imported by the parser and the top level.
package nrmc_pkg;

	localparam int unsigned ADDR_W = 3;
	localparam logic [ADDR_W-1:0] REG_HOUR_OFFSET = 3'd0;
	localparam logic [4:0] HOUR_OFFSET_RST = 5'd8;

	localparam logic [7:0] CH_STAR   = 8'h2A; // '*'
	localparam logic [7:0] CH_COMMA  = 8'h2C; // ','
	localparam logic [7:0] CH_ZERO   = 8'h30; // '0'
	localparam logic [7:0] CH_NINE   = 8'h39; // '9'
	localparam logic [7:0] CH_UPPER_A = 8'h41; // 'A'
	localparam logic [7:0] CH_UPPER_F = 8'h46; // 'F'
	localparam logic [7:0] CH_ACTIVE = 8'h41; // 'A' status: active fix

	localparam logic [7:0] POS_TIME_FIRST = 8'd7;
	localparam logic [7:0] POS_TIME_LAST  = 8'd12;
	localparam logic [7:0] POS_MAX        = 8'd255;

	typedef struct packed {
		logic [4:0] hours;
		logic [6:0] minutes;
		logic [6:0] seconds;
		logic       time_updated;
		logic       end_seen;
	} nrmc_result_t;

	// "$GPRMC", indexed by position 0..5
	function automatic logic [7:0] prefix_char(input logic [2:0] idx);
		logic [7:0] ch;
		case (idx)
			3'd0: ch = 8'h24;
			3'd1: ch = 8'h47;
			3'd2: ch = 8'h50;
			3'd3: ch = 8'h52;
			3'd4: ch = 8'h4D;
			3'd5: ch = 8'h43;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	// "END", indexed by position 0..2
	function automatic logic [7:0] end_char(input logic [1:0] idx);
		logic [7:0] ch;
		case (idx)
			2'd0: ch = 8'h45;
			2'd1: ch = 8'h4E;
			2'd2: ch = 8'h44;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	// Uppercase hex digit value in [3:0]; bit 4 flags a non-hex character.
	function automatic logic [4:0] hex_value(input logic [7:0] ch);
		logic [4:0] v;
		if (ch >= CH_ZERO && ch <= CH_NINE) begin
			v = {1'b0, 4'(ch - CH_ZERO)};
		end else if (ch >= CH_UPPER_A && ch <= CH_UPPER_F) begin
			v = {1'b0, 4'(ch - CH_UPPER_A + 8'd10)};
		end else begin
			v = 5'h10;
		end
		return v;
	endfunction

	// Value below 144 reduced modulo 24 by three compare-subtract steps.
	function automatic logic [4:0] mod24(input logic [7:0] x);
		logic [7:0] r;
		r = x;
		if (r >= 8'd96) r = r - 8'd96;
		if (r >= 8'd48) r = r - 8'd48;
		if (r >= 8'd24) r = r - 8'd24;
		return r[4:0];
	endfunction

endpackage

// ===== hdl/nmea_rmc_sentence_checker_top.sv =====
// A character beat enters the input register; a token's last character then loads
// its result from the parser into the output register when that beat is consumed.
// Throughput: one character per cycle, except while a last-character beat waits on the output.
// An output stall blocks only last-character beats; others keep flowing.
// Reset (arst_n low, asynchronous): channels empty, stored time 0, offset 8.
// Top level of the RMC sentence checker; APB register, input/output registers.
// Depends on nrmc_pkg, nrmc_parse and the assertion macro header.
`include "nmea_rmc_sentence_checker_top_defines.svh"
module nmea_rmc_sentence_checker_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [nrmc_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [7:0]                  char_in,
	input  logic                        last_char,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [4:0]                  hours,
	output logic [6:0]                  minutes,
	output logic [6:0]                  seconds,
	output logic                        time_updated,
	output logic                        end_seen
);
	import nrmc_pkg::*;

	logic [4:0]   offset_q;
	logic         valid_s1, last_s1;
	logic [7:0]   char_s1;
	logic         consume;
	logic         out_valid_q;
	nrmc_result_t res, res_q;

	assign pready = 1'b1;
	assign prdata = (paddr == REG_HOUR_OFFSET) ? {27'd0, offset_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= HOUR_OFFSET_RST;
		end else if (psel && penable && pwrite && paddr == REG_HOUR_OFFSET) begin
			offset_q <= pwdata[4:0];
		end
	end

	// A beat without a result never waits on the output side.
	assign consume  = valid_s1 && (!last_s1 || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			char_s1 <= char_in;
			last_s1 <= last_char;
		end
	end

	nrmc_parse u_parse (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (consume),
		.char_in     (char_s1),
		.last_char   (last_s1),
		.hour_offset (offset_q),
		.result      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (consume && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (consume && last_s1) res_q <= res;
	end

	assign out_valid    = out_valid_q;
	assign hours        = res_q.hours;
	assign minutes      = res_q.minutes;
	assign seconds      = res_q.seconds;
	assign time_updated = res_q.time_updated;
	assign end_seen     = res_q.end_seen;

	`NRMC_ASSERT(a_out_hold, clk, arst_n, out_valid && out_stall |=> out_valid, "result beat lost under stall")
	`NRMC_ASSERT(a_hours_range, clk, arst_n, out_valid |-> hours < 5'd24, "hours out of range")
	`NRMC_ASSERT(a_excl, clk, arst_n, out_valid |-> !(time_updated && end_seen), "END token accepted as fix")
	`NRMC_ASSERT(a_src, clk, arst_n, $rose(out_valid) |-> $past(valid_s1 && last_s1), "result without token end")
	`NRMC_ASSERT_ALWAYS(a_rst_empty, clk, !arst_n |-> !out_valid && !in_stall, "channels not empty in reset")

endmodule

// ===== hdl/nrmc_parse.sv =====
// Per-token parser: prefix, END word, checksum, time digits and status, plus stored time.
// Depends on nrmc_pkg; result is valid combinationally for the beat in step.
module nrmc_parse (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [7:0]            char_in,
	input  logic                  last_char,
	input  logic [4:0]            hour_offset,
	output nrmc_pkg::nrmc_result_t result
);
	import nrmc_pkg::*;

	typedef enum logic [1:0] {PH_STAR, PH_HEX1, PH_HEX2, PH_DONE} chk_phase_t;
	typedef enum logic [1:0] {ST_SEEK, ST_NEXT, ST_DONE} stat_phase_t;

	logic [7:0]  pos_q;
	chk_phase_t  chk_q, chk_n;
	stat_phase_t stat_q, stat_n;
	logic        prefix_q, prefix_n;
	logic        endm_q, endm_n;
	logic [7:0]  xor_q, xor_n;
	logic [7:0]  rcv_q, rcv_n;
	logic        bad_q, bad_n;
	logic        stok_q, stok_n;
	logic [6:0]  pend_q [3];
	logic [6:0]  pend_n [3];
	logic [4:0]  hrs_q;
	logic [6:0]  min_q, sec_q;

	logic        in_time, is_digit, accepted;
	logic [3:0]  digit, toff;
	logic [1:0]  k;
	logic [4:0]  hv;

	always_comb begin
		prefix_n = prefix_q;
		endm_n   = endm_q;
		bad_n    = bad_q;
		xor_n    = xor_q;
		rcv_n    = rcv_q;
		chk_n    = chk_q;
		stat_n   = stat_q;
		stok_n   = stok_q;
		for (int i = 0; i < 3; i++) pend_n[i] = pend_q[i];

		if (pos_q < 8'd6 && char_in != prefix_char(pos_q[2:0])) prefix_n = 1'b0;
		if (pos_q >= 8'd3 || char_in != end_char(pos_q[1:0])) endm_n = 1'b0;

		in_time  = (pos_q >= POS_TIME_FIRST) && (pos_q <= POS_TIME_LAST);
		is_digit = (char_in >= CH_ZERO) && (char_in <= CH_NINE);
		digit    = 4'(char_in - CH_ZERO);
		toff     = 4'(pos_q[3:0] - 4'd7);
		k        = toff[2:1];
		if (in_time) begin
			if (!is_digit) begin
				bad_n = 1'b1;
			end else if (!toff[0]) begin
				pend_n[k] = 7'(digit) * 7'd10;
			end else begin
				pend_n[k] = pend_q[k] + 7'(digit);
			end
		end

		hv = hex_value(char_in);
		case (chk_q)
			PH_STAR: begin
				if (char_in == CH_STAR) chk_n = PH_HEX1;
				else if (pos_q != 8'd0) xor_n = xor_q ^ char_in;
			end
			PH_HEX1: begin
				if (hv[4]) bad_n = 1'b1;
				else rcv_n = {hv[3:0], 4'd0};
				chk_n = PH_HEX2;
			end
			PH_HEX2: begin
				if (hv[4]) bad_n = 1'b1;
				else rcv_n = {rcv_q[7:4], hv[3:0]};
				chk_n = PH_DONE;
			end
			default: ;
		endcase

		case (stat_q)
			ST_SEEK: begin
				if (pos_q >= POS_TIME_FIRST && char_in == CH_COMMA) stat_n = ST_NEXT;
			end
			ST_NEXT: begin
				stok_n = (char_in == CH_ACTIVE);
				stat_n = ST_DONE;
			end
			default: ;
		endcase

		accepted = prefix_n && (pos_q >= POS_TIME_LAST) && !bad_n && (chk_n == PH_DONE)
			&& (xor_n == rcv_n) && stok_n;

		result.hours        = accepted ? mod24(8'(pend_n[0]) + 8'(hour_offset)) : hrs_q;
		result.minutes      = accepted ? pend_n[1] : min_q;
		result.seconds      = accepted ? pend_n[2] : sec_q;
		result.time_updated = accepted;
		result.end_seen     = endm_n && (pos_q == 8'd2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			chk_q    <= PH_STAR;
			stat_q   <= ST_SEEK;
			prefix_q <= 1'b1;
			endm_q   <= 1'b1;
			xor_q    <= '0;
			rcv_q    <= '0;
			bad_q    <= 1'b0;
			stok_q   <= 1'b0;
			for (int i = 0; i < 3; i++) pend_q[i] <= '0;
			hrs_q    <= '0;
			min_q    <= '0;
			sec_q    <= '0;
		end else if (step) begin
			if (last_char) begin
				// token end: commit time, drop all per-token state
				hrs_q    <= result.hours;
				min_q    <= result.minutes;
				sec_q    <= result.seconds;
				pos_q    <= '0;
				chk_q    <= PH_STAR;
				stat_q   <= ST_SEEK;
				prefix_q <= 1'b1;
				endm_q   <= 1'b1;
				xor_q    <= '0;
				rcv_q    <= '0;
				bad_q    <= 1'b0;
				stok_q   <= 1'b0;
				for (int i = 0; i < 3; i++) pend_q[i] <= '0;
			end else begin
				if (pos_q != POS_MAX) pos_q <= pos_q + 8'd1;
				chk_q    <= chk_n;
				stat_q   <= stat_n;
				prefix_q <= prefix_n;
				endm_q   <= endm_n;
				xor_q    <= xor_n;
				rcv_q    <= rcv_n;
				bad_q    <= bad_n;
				stok_q   <= stok_n;
				for (int i = 0; i < 3; i++) pend_q[i] <= pend_n[i];
			end
		end
	end

endmodule

// ===== tb/sv/rmc_time_checker.sv =====
// Checker for the RMC sentence checker: follows the APB port and both beat channels.
// Predicts each token's result and compares it field by field. Depends on nrmc_pkg.
module rmc_time_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [nrmc_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	input  logic [31:0]                 prdata,
	input  logic                        pready,
	input  logic                        in_valid,
	input  logic                        in_stall,
	input  logic [7:0]                  char_in,
	input  logic                        last_char,
	input  logic                        out_valid,
	input  logic                        out_stall,
	input  logic [4:0]                  hours,
	input  logic [6:0]                  minutes,
	input  logic [6:0]                  seconds,
	input  logic                        time_updated,
	input  logic                        end_seen,
	input  logic                        wrap_up,
	output int                          fail_count,
	output int                          pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import nrmc_pkg::*;

	typedef enum logic [1:0] {SUM_BODY, SUM_HIGH, SUM_LOW, SUM_DONE} sum_phase_e;
	typedef enum logic [1:0] {FIX_SEEK, FIX_NEXT, FIX_DONE} fix_phase_e;

	localparam logic [47:0] RMC_HEAD = "$GPRMC";
	localparam logic [23:0] END_WORD = "END";
	localparam int HOURS_PER_DAY = 24;

	logic [4:0]   offset;
	logic [7:0]   tok_pos;
	sum_phase_e   sum_phase;
	fix_phase_e   fix_phase;
	logic         head_ok;
	logic         end_ok;
	logic         digit_bad;
	logic         fix_ok;
	logic [7:0]   run_xor;
	logic [7:0]   check_byte;
	logic [6:0]   time_acc [3];
	logic [4:0]   stored_hh;
	logic [6:0]   stored_mm;
	logic [6:0]   stored_ss;
	logic         wrapped;
	nrmc_result_t expected_times [$];
	nrmc_result_t seen;
	nrmc_result_t want;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] exp_val);
		$display("checker: %s: got %0d, expected %0d", what, got, exp_val);
		fail_count++;
	endtask

	function automatic logic [4:0] hex_nibble(input logic [7:0] c);
		if (c >= CH_ZERO && c <= CH_NINE) return 5'(c - CH_ZERO);
		if (c >= CH_UPPER_A && c <= CH_UPPER_F) return 5'(c - CH_UPPER_A) + 5'd10;
		return 5'h10;
	endfunction

	task automatic clear_token();
		tok_pos = '0;
		sum_phase = SUM_BODY;
		fix_phase = FIX_SEEK;
		head_ok = 1'b1;
		end_ok = 1'b1;
		digit_bad = 1'b0;
		fix_ok = 1'b0;
		run_xor = '0;
		check_byte = '0;
		foreach (time_acc[i]) time_acc[i] = '0;
	endtask

	// One character beat of the current token; a last beat closes the token.
	task automatic advance_parse(input logic [7:0] c, input logic last);
		int p;
		int k;
		logic [4:0] nib;
		logic accepted;
		p = int'(tok_pos);
		if (p < 6) begin
			if (c != RMC_HEAD[8*(5-p) +: 8]) head_ok = 1'b0;
		end
		if (p >= 3) end_ok = 1'b0;
		else if (c != END_WORD[8*(2-p) +: 8]) end_ok = 1'b0;

		if (p >= int'(POS_TIME_FIRST) && p <= int'(POS_TIME_LAST)) begin
			if (c < CH_ZERO || c > CH_NINE) begin
				digit_bad = 1'b1;
			end else begin
				k = (p - int'(POS_TIME_FIRST)) / 2;
				if (((p - int'(POS_TIME_FIRST)) % 2) == 0) time_acc[k] = 7'((c - CH_ZERO) * 8'd10);
				else time_acc[k] = time_acc[k] + 7'(c - CH_ZERO);
			end
		end

		case (sum_phase)
			SUM_BODY: begin
				if (c == CH_STAR) sum_phase = SUM_HIGH;
				else if (p >= 1) run_xor = run_xor ^ c;
			end
			SUM_HIGH: begin
				nib = hex_nibble(c);
				if (nib[4]) digit_bad = 1'b1;
				else check_byte = {nib[3:0], 4'h0};
				sum_phase = SUM_LOW;
			end
			SUM_LOW: begin
				nib = hex_nibble(c);
				if (nib[4]) digit_bad = 1'b1;
				else check_byte = check_byte | {4'h0, nib[3:0]};
				sum_phase = SUM_DONE;
			end
			default: ;
		endcase

		case (fix_phase)
			FIX_SEEK: if (p >= int'(POS_TIME_FIRST) && c == CH_COMMA) fix_phase = FIX_NEXT;
			FIX_NEXT: begin
				fix_ok = (c == CH_ACTIVE);
				fix_phase = FIX_DONE;
			end
			default: ;
		endcase

		if (tok_pos != POS_MAX) tok_pos++;

		if (last) begin
			accepted = head_ok && p >= int'(POS_TIME_LAST) && !digit_bad &&
				sum_phase == SUM_DONE && run_xor == check_byte && fix_ok;
			if (accepted) begin
				stored_hh = 5'((int'(time_acc[0]) + int'(offset)) % HOURS_PER_DAY);
				stored_mm = time_acc[1];
				stored_ss = time_acc[2];
			end
			expected_times.push_back('{stored_hh, stored_mm, stored_ss, accepted,
				end_ok && p == 2});
			clear_token();
		end
	endtask

	initial begin
		fail_count = 0;
		pending = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset = HOUR_OFFSET_RST;
			clear_token();
			stored_hh = '0;
			stored_mm = '0;
			stored_ss = '0;
			wrapped = 1'b0;
			expected_times.delete();
		end else begin
			if (out_valid && !out_stall) begin
				seen = '{hours, minutes, seconds, time_updated, end_seen};
				if (expected_times.size() == 0) begin
					report_mismatch("result beat with nothing expected", 32'(seen), 0);
				end else begin
					want = expected_times.pop_front();
					if (seen.hours !== want.hours)
						report_mismatch("hours", seen.hours, want.hours);
					if (seen.minutes !== want.minutes)
						report_mismatch("minutes", seen.minutes, want.minutes);
					if (seen.seconds !== want.seconds)
						report_mismatch("seconds", seen.seconds, want.seconds);
					if (seen.time_updated !== want.time_updated)
						report_mismatch("time_updated", seen.time_updated, want.time_updated);
					if (seen.end_seen !== want.end_seen)
						report_mismatch("end_seen", seen.end_seen, want.end_seen);
				end
			end
			if (in_valid && !in_stall) advance_parse(char_in, last_char);
			if (psel && penable && pready && paddr == REG_HOUR_OFFSET) begin
				if (pwrite) offset = pwdata[4:0];
				else if (prdata !== 32'(offset)) report_mismatch("hour_offset read", prdata, offset);
			end
			if (wrap_up && !wrapped) begin
				wrapped = 1'b1;
				if (expected_times.size() != 0)
					report_mismatch("results never delivered", expected_times.size(), 0);
			end
		end
		pending = expected_times.size();
	end

endmodule

// ===== tb/sv/tb_top.sv =====
// Top of the RMC sentence checker testbench: clock, reset, APB writes, token stimulus.
// Depends on nrmc_pkg, nmea_rmc_sentence_checker_top and rmc_time_checker.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import nrmc_pkg::*;

	typedef enum int {
		TK_GOOD, TK_BAD_SUM, TK_VOID, TK_NO_STAR, TK_SHORT_CHECK, TK_LOWER_HEX,
		TK_NON_HEX, TK_BAD_DIGIT, TK_NO_STATUS, TK_COMMA_LAST, TK_EXTRA, TK_BAD_HEAD,
		TK_TRUNC, TK_LONG, TK_END, TK_NEAR_END, TK_NOISE
	} token_kind_e;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int CHARS_PER_PHASE = 150;
	localparam int SETTLE_CYCLES = 4;
	localparam logic [7:0] CH_LOWER_A = 8'h61;

	logic                clk;
	logic                arst_n = 1'b1;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [ADDR_W-1:0]   paddr = '0;
	logic [31:0]         pwdata = '0;
	logic [31:0]         prdata;
	logic                pready;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [7:0]          char_in = '0;
	logic                last_char = 1'b0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [4:0]          hours;
	logic [6:0]          minutes;
	logic [6:0]          seconds;
	logic                time_updated;
	logic                end_seen;
	logic                wrap_up = 1'b0;
	int                  fail_count;
	int                  pending;

	int                  send_idle_pct = 0;
	int                  recv_idle_pct = 0;
	logic [7:0]          tok [$];
	string               field_set = "0123456789.,NSEW";

	nmea_rmc_sentence_checker_top u_top (.*);

	rmc_time_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) out_stall <= ($urandom_range(99) < recv_idle_pct);

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) idle_cycles = 0;
			else idle_cycles++;
		end
		$display("tb: failure");
		$finish;
	end

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		return (v < 4'd10) ? CH_ZERO + 8'(v) : CH_UPPER_A + 8'(v) - 8'd10;
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_UPPER_A && c <= CH_UPPER_F);
	endfunction

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++) tok.push_back(s[i]);
	endtask

	task automatic push_digit();
		tok.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
	endtask

	// Build one token of the given kind into tok; tm forces the time digits.
	task automatic make_token(input token_kind_e kind, input string tm);
		logic [7:0] sum;
		logic [7:0] c;
		int n;
		tok.delete();
		if (kind == TK_END) begin
			push_text("END");
			return;
		end
		if (kind == TK_NEAR_END) begin
			case ($urandom_range(0, 3))
				0: push_text("EN");
				1: push_text("ENDS");
				2: push_text("XND");
				default: push_text("E");
			endcase
			return;
		end
		if (kind == TK_NOISE) begin
			repeat ($urandom_range(1, 16)) tok.push_back(8'($urandom_range(0, 255)));
			return;
		end

		push_text("$GPRMC,");
		if (tm.len() == 6) push_text(tm);
		else repeat (6) push_digit();
		if (kind == TK_BAD_DIGIT) begin
			do c = 8'($urandom_range(0, 255)); while (c >= CH_ZERO && c <= CH_NINE);
			tok[$urandom_range(POS_TIME_FIRST, POS_TIME_LAST)] = c;
		end
		if (kind != TK_NO_STATUS) begin
			if ($urandom_range(0, 1)) begin
				push_text(".");
				push_digit();
				push_digit();
			end
			tok.push_back(CH_COMMA);
			if (kind == TK_COMMA_LAST) return;
			if (kind == TK_VOID) begin
				do c = 8'($urandom_range(33, 126)); while (c == CH_ACTIVE || c == CH_STAR);
				tok.push_back(c);
			end else begin
				tok.push_back(CH_ACTIVE);
			end
			n = (kind == TK_LONG) ? $urandom_range(250, 300) : $urandom_range(0, 12);
			repeat (n) tok.push_back(field_set[$urandom_range(0, field_set.len() - 1)]);
		end
		if (kind == TK_BAD_HEAD) tok[$urandom_range(0, 5)] ^= 8'($urandom_range(1, 255));
		if (kind == TK_NO_STAR) return;

		sum = '0;
		for (int i = 1; i < tok.size(); i++) sum ^= tok[i];
		if (kind == TK_BAD_SUM) sum ^= 8'($urandom_range(1, 255));
		tok.push_back(CH_STAR);
		if (kind == TK_SHORT_CHECK) begin
			if ($urandom_range(0, 1)) tok.push_back(hex_char(sum[7:4]));
			return;
		end
		tok.push_back(hex_char(sum[7:4]));
		tok.push_back(hex_char(sum[3:0]));
		n = tok.size() - 1 - $urandom_range(0, 1);
		if (kind == TK_LOWER_HEX) tok[n] = CH_LOWER_A + 8'($urandom_range(0, 5));
		if (kind == TK_NON_HEX) begin
			do c = 8'($urandom_range(0, 255)); while (is_hex(c));
			tok[n] = c;
		end
		if (kind == TK_EXTRA) repeat ($urandom_range(1, 6)) tok.push_back(8'($urandom_range(33, 126)));
		if (kind == TK_TRUNC) begin
			n = $urandom_range(1, tok.size() - 1);
			while (tok.size() > n) void'(tok.pop_back());
		end
	endtask

	task automatic send_beat(input logic [7:0] c, input logic last);
		int gap;
		gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 4) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		char_in <= c;
		last_char <= last;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic send_token(input token_kind_e kind, input string tm);
		make_token(kind, tm);
		foreach (tok[i]) send_beat(tok[i], i == tok.size() - 1);
	endtask

	// Hold the sender until every expected result beat has come out.
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [31:0] d);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= REG_HOUR_OFFSET;
		pwdata <= d;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_hour_offset(input logic [4:0] value);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		apb_access(1'b1, 32'(value));
		apb_access(1'b0, '0);
	endtask

	function automatic token_kind_e pick_kind();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) return TK_GOOD;
		if (r < 68) return TK_END;
		if (r == 68) return TK_LONG;
		return token_kind_e'($urandom_range(0, int'(TK_NOISE)));
	endfunction

	initial begin
		logic [4:0] offsets [4];
		int sent;
		offsets = '{5'd0, 5'd23, 5'd31, 5'($urandom_range(0, 31))};
		// assert reset by an edge so every asynchronous reset branch runs
		arst_n <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset offset first, then the extremes of the time digits and every kind once
		apb_access(1'b0, '0);
		send_token(TK_GOOD, "000000");
		send_token(TK_GOOD, "235959");
		send_token(TK_GOOD, "999999");
		for (int k = 0; k <= int'(TK_NOISE); k++) send_token(token_kind_e'(k), "");
		tok.delete();
		tok.push_back(8'($urandom_range(0, 255)));
		send_beat(tok[0], 1'b1);

		for (int ph = 0; ph < 4; ph++) begin
			set_hour_offset(offsets[ph]);
			case (ph)
				0: begin send_idle_pct = 23; recv_idle_pct = 64; end
				1: begin send_idle_pct = 64; recv_idle_pct = 23; end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			if (ph == 2) send_token(TK_GOOD, "235959");
			sent = 0;
			while (sent < CHARS_PER_PHASE) begin
				if ($urandom_range(0, 19) == 0) wait_drained();
				send_token(pick_kind(), "");
				sent += tok.size();
			end
		end

		wait_drained();
		repeat (10) @(posedge clk);
		wrap_up <= 1'b1;
		repeat (2) @(posedge clk);
		if (fail_count == 0) $display("tb: success");
		else $display("tb: failure");
		$finish;
	end

endmodule
